// ===== src/bhmh_pkg.sv =====
`timescale 1ns / 1ps
package bhmh_pkg;
    localparam int BinCountDef  = 255;
    localparam int HeapDepthDef = 256;
    localparam int KeyWidthDef  = 32;

    localparam logic [1:0] OP_COUNT   = 2'd0;
    localparam logic [1:0] OP_BUILD   = 2'd1;
    localparam logic [1:0] OP_EXTRACT = 2'd2;
    localparam logic [1:0] OP_INSERT  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  byte_value;
        logic [31:0] new_key;
        logic [7:0]  new_symbol;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_key;
        logic [7:0]  out_symbol;
        logic [8:0]  heap_count;
    } t_out_word;
endpackage

// ===== src/bhmh_bin_mem.sv =====
`timescale 1ns / 1ps
module bhmh_bin_mem
    import bhmh_pkg::*;
#(
    parameter int BIN_COUNT = BinCountDef,
    parameter int KEY_WIDTH = KeyWidthDef,
    localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1
) (
    input  logic                 i_clk,
    input  logic [BW-1:0]        i_raddr,
    output logic [KEY_WIDTH-1:0] o_rcount,
    output logic [7:0]           o_rfirst,
    input  logic                 i_we,
    input  logic [BW-1:0]        i_waddr,
    input  logic [KEY_WIDTH-1:0] i_wcount,
    input  logic [7:0]           i_wfirst
);
    logic [KEY_WIDTH+7:0] r_mem [BIN_COUNT];

    // write then registered read of one bin
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wcount, i_wfirst};
        end
        {o_rcount, o_rfirst} <= r_mem[i_raddr];
    end
endmodule

// ===== src/bhmh_heap_mem.sv =====
`timescale 1ns / 1ps
module bhmh_heap_mem
    import bhmh_pkg::*;
#(
    parameter int HEAP_DEPTH = HeapDepthDef,
    parameter int KEY_WIDTH  = KeyWidthDef,
    localparam int HW = $clog2(HEAP_DEPTH)
) (
    input  logic                 i_clk,
    input  logic [HW-1:0]        i_raddr_a,
    input  logic [HW-1:0]        i_raddr_b,
    output logic [KEY_WIDTH+7:0] o_rdata_a,
    output logic [KEY_WIDTH+7:0] o_rdata_b,
    input  logic                 i_we,
    input  logic [HW-1:0]        i_waddr,
    input  logic [KEY_WIDTH+7:0] i_wdata
);
    logic [KEY_WIDTH+7:0] r_mem [HEAP_DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== src/byte_histogram_min_heap_core.sv =====
`timescale 1ns / 1ps
// Channel | Ports                      | Handshake
// command | i_start, i_word, o_busy    | taken when i_start && !o_busy
// result  | o_valid, o_word            | one-cycle strobe, no back pressure
//
// While busy, a count reads then writes its bin; an empty extract or a full insert goes straight to done.
// Extract reads the root and the last entry, then sinks level by level; insert climbs level by level.
// Build copies the nonzero bins into the heap, then sifts down each parent from the last one;
// each level is one registered heap read followed by one compare and write.
// After reset the bin memory is cleared one bin a cycle, busy high.
// Results cannot be stalled; o_valid pulses in the first idle cycle, when a word may be taken.
module byte_histogram_min_heap_core
    import bhmh_pkg::*;
#(
    parameter int BIN_COUNT  = BinCountDef,
    parameter int HEAP_DEPTH = HeapDepthDef,
    parameter int KEY_WIDTH  = KeyWidthDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_word,
    output logic      o_busy,
    output logic      o_valid,
    output t_out_word o_word
);
    localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int HW = $clog2(HEAP_DEPTH);
    localparam int SW = HW + 1;
    localparam int EW = KEY_WIDTH + 8;
    localparam int KO = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int BC = $clog2(BIN_COUNT + 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CWR   = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BWR   = 4'd5;
    localparam logic [3:0] S_BHEAP = 4'd6;
    localparam logic [3:0] S_DLD   = 4'd7;
    localparam logic [3:0] S_DGET  = 4'd8;
    localparam logic [3:0] S_DRD   = 4'd9;
    localparam logic [3:0] S_DCMP  = 4'd10;
    localparam logic [3:0] S_URD   = 4'd11;
    localparam logic [3:0] S_UCMP  = 4'd12;
    localparam logic [3:0] S_XRD   = 4'd13;
    localparam logic [3:0] S_XWR   = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]           r_state;
    logic [SW-1:0]        r_size;
    logic [BC-1:0]        r_bin;
    logic [SW-1:0]        r_pos;
    logic [SW-1:0]        r_par;
    logic                 r_build;
    logic [EW-1:0]        r_cur;
    logic [1:0]           r_status;
    logic [KEY_WIDTH-1:0] r_okey;
    logic [7:0]           r_osym;
    logic [7:0]           r_byte;
    logic [BW-1:0]        r_baddr;
    logic                 r_valid;

    logic [BW-1:0]        bin_raddr;
    logic [KEY_WIDTH-1:0] bin_rcount;
    logic [7:0]           bin_rfirst;
    logic                 bin_we;
    logic [BW-1:0]        bin_waddr;
    logic [KEY_WIDTH-1:0] bin_wcount;
    logic [7:0]           bin_wfirst;

    logic [HW-1:0]        h_ra, h_rb, h_wa;
    logic [EW-1:0]        h_da, h_db, h_wd;
    logic                 h_we;

    logic [KEY_WIDTH-1:0] key_max;
    logic [BW-1:0]        bin_lut [256];
    logic [BW-1:0]        bmod;
    logic [SW:0]          left, right;
    logic                 has_r;
    logic                 take_r;
    logic                 sink;
    logic [EW-1:0]        child_e;
    logic [SW-1:0]        child_i;
    logic [SW-1:0]        par_i;
    logic [SW-1:0]        size_m1;

    assign key_max = '1;

    // byte mod BIN_COUNT from a constant table
    for (genvar g = 0; g < 256; g++) begin : g_bin_lut
        assign bin_lut[g] = BW'(g % BIN_COUNT);
    end
    assign bmod = bin_lut[i_word.byte_value];

    bhmh_bin_mem #(.BIN_COUNT(BIN_COUNT), .KEY_WIDTH(KEY_WIDTH)) u_bins (
        .i_clk   (i_clk),
        .i_raddr (bin_raddr),
        .o_rcount(bin_rcount),
        .o_rfirst(bin_rfirst),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wcount(bin_wcount),
        .i_wfirst(bin_wfirst)
    );

    bhmh_heap_mem #(.HEAP_DEPTH(HEAP_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_heap (
        .i_clk    (i_clk),
        .i_raddr_a(h_ra),
        .i_raddr_b(h_rb),
        .o_rdata_a(h_da),
        .o_rdata_b(h_db),
        .i_we     (h_we),
        .i_waddr  (h_wa),
        .i_wdata  (h_wd)
    );

    assign left    = {r_pos, 1'b1};
    assign right   = {r_pos, 1'b0} + (SW+1)'(2);
    assign has_r   = right < {1'b0, r_size};
    assign size_m1 = r_size - SW'(1);
    assign par_i   = (r_pos - SW'(1)) >> 1;

    // pick the smaller child, ties to the left; sink while the child is strictly smaller
    assign take_r  = has_r && (h_db[EW-1:8] < h_da[EW-1:8]);
    assign child_e = take_r ? h_db : h_da;
    assign child_i = take_r ? right[SW-1:0] : left[SW-1:0];
    assign sink    = child_e[EW-1:8] < r_cur[EW-1:8];

    // memory addresses
    always_comb begin
        bin_raddr  = r_baddr;
        bin_we     = 1'b0;
        bin_waddr  = r_baddr;
        bin_wcount = '0;
        bin_wfirst = r_byte;
        h_ra = r_pos[HW-1:0];
        h_rb = r_pos[HW-1:0];
        h_we = 1'b0;
        h_wa = r_pos[HW-1:0];
        h_wd = r_cur;
        unique case (r_state)
            S_CLEAR: begin
                bin_we    = 1'b1;
                bin_waddr = r_bin[BW-1:0];
            end
            S_IDLE: bin_raddr = bmod;
            S_CWR: begin
                bin_we = 1'b1;
                if (bin_rcount == '0) begin
                    bin_wcount = KEY_WIDTH'(1);
                end else if (bin_rcount == key_max) begin
                    bin_wcount = bin_rcount;
                    bin_wfirst = bin_rfirst;
                end else begin
                    bin_wcount = bin_rcount + KEY_WIDTH'(1);
                    bin_wfirst = bin_rfirst;
                end
            end
            S_BRD: bin_raddr = r_bin[BW-1:0];
            S_BWR: begin
                h_we = (bin_rcount != '0) && (r_size < SW'(HEAP_DEPTH));
                h_wa = r_size[HW-1:0];
                h_wd = {bin_rcount, bin_rfirst};
            end
            S_DLD: h_ra = r_par[HW-1:0];
            S_DRD: begin
                h_ra = left[HW-1:0];
                h_rb = (has_r ? right[HW-1:0] : left[HW-1:0]);
                // no child: drop the entry into its slot
                h_we = (left >= {1'b0, r_size});
            end
            S_DCMP: begin
                h_we = 1'b1;
                h_wd = sink ? child_e : r_cur;
            end
            S_URD: begin
                h_ra = par_i[HW-1:0];
                h_we = (r_pos == '0);
            end
            S_UCMP: begin
                h_we = 1'b1;
                h_wd = (r_cur[EW-1:8] < h_da[EW-1:8]) ? h_da : r_cur;
            end
            S_XRD: begin
                h_ra = '0;
                h_rb = size_m1[HW-1:0];
            end
            default: ;
        endcase
    end

    // strobe the result the cycle after the last step
    always_ff @(posedge i_clk) begin
        r_valid <= i_rst_n && (r_state == S_DONE);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_size  <= '0;
            r_bin   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_bin <= r_bin + BC'(1);
                    if (r_bin == BC'(BIN_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (i_start) begin
                    r_okey  <= '0;
                    r_osym  <= '0;
                    r_byte  <= i_word.byte_value;
                    r_baddr <= bmod;
                    r_build <= (i_word.op == OP_BUILD);
                    unique case (i_word.op)
                        OP_COUNT: begin
                            r_status <= ST_OK;
                            r_state  <= S_CRD;
                        end
                        OP_BUILD: begin
                            r_status <= ST_OK;
                            r_bin    <= '0;
                            r_size   <= '0;
                            r_state  <= S_BRD;
                        end
                        OP_EXTRACT: begin
                            if (r_size == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_XRD;
                            end
                        end
                        OP_INSERT: begin
                            if (r_size >= SW'(HEAP_DEPTH)) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_cur    <= {KEY_WIDTH'(i_word.new_key), i_word.new_symbol};
                                r_pos    <= r_size;
                                r_size   <= r_size + SW'(1);
                                r_state  <= S_URD;
                            end
                        end
                        default: ;
                    endcase
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    r_okey  <= bin_wcount;
                    r_osym  <= bin_wfirst;
                    if (bin_rcount == key_max) r_status <= ST_FULL;
                    r_state <= S_DONE;
                end
                // copy nonzero bins into the heap
                S_BRD: r_state <= S_BWR;
                S_BWR: begin
                    if (bin_rcount != '0 && r_size < SW'(HEAP_DEPTH)) begin
                        r_size <= r_size + SW'(1);
                    end
                    r_bin <= r_bin + BC'(1);
                    if (r_bin == BC'(BIN_COUNT - 1)) begin
                        r_state <= S_BHEAP;
                    end else begin
                        r_state <= S_BRD;
                    end
                end
                // start heapify at the last parent
                S_BHEAP: begin
                    if (r_size > SW'(1)) begin
                        r_par   <= (r_size - SW'(2)) >> 1;
                        r_state <= S_DLD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DLD: r_state <= S_DGET;
                S_DGET: begin
                    r_cur   <= h_da;
                    r_pos   <= r_par;
                    r_state <= S_DRD;
                end
                S_XRD: r_state <= S_XWR;
                S_XWR: begin
                    r_okey  <= h_da[EW-1:8];
                    r_osym  <= h_da[7:0];
                    r_size  <= size_m1;
                    r_cur   <= h_db;
                    r_pos   <= '0;
                    r_state <= S_DRD;
                end
                // sift-down: read children, then compare and write
                S_DRD: begin
                    if (left >= {1'b0, r_size}) begin
                        if (r_build && r_par != '0) begin
                            r_par   <= r_par - SW'(1);
                            r_state <= S_DLD;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_state <= S_DCMP;
                    end
                end
                S_DCMP: begin
                    if (sink) begin
                        // parent slot takes the child, hole moves down
                        r_pos   <= child_i;
                        r_state <= S_DRD;
                    end else if (r_build && r_par != '0) begin
                        r_par   <= r_par - SW'(1);
                        r_state <= S_DLD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // sift-up: read parent, then compare and write
                S_URD: begin
                    if (r_pos == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_par   <= par_i;
                        r_state <= S_UCMP;
                    end
                end
                S_UCMP: begin
                    if (r_cur[EW-1:8] < h_da[EW-1:8]) begin
                        r_pos   <= r_par;
                        r_state <= S_URD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // hold the result word
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE) begin
            o_word.status     <= r_status;
            o_word.out_key    <= 32'(r_okey[KO-1:0]);
            o_word.out_symbol <= r_osym;
            o_word.heap_count <= 9'(r_size);
        end
    end

    assign o_valid = r_valid;
    assign o_busy  = (r_state != S_IDLE);
endmodule

// ===== src/bhmh_checker.sv =====
`timescale 1ns / 1ps
module bhmh_checker
    import bhmh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_valid,
    input t_out_word o_word
);
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("double strobe");
    a_busy_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy) else $error("result while busy");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.status != 2'd3)) else $error("bad status");
endmodule

bind byte_histogram_min_heap_core bhmh_checker u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy (o_busy),
    .o_valid(o_valid),
    .o_word (o_word)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import bhmh_pkg::*;

    localparam int NBINS     = 255;
    localparam int HEAP_CAP  = 256;
    localparam int RAND_OPS  = 470;
    localparam int CYCLE_CAP = 900000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_word  cmd_word = '0;
    logic      busy;
    logic      res_valid;
    t_out_word res_word;

    byte_histogram_min_heap_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_word(cmd_word),
        .o_busy(busy), .o_valid(res_valid), .o_word(res_word)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow state of the histogram and heap
    logic [31:0] hist_cnt [NBINS];
    logic [7:0]  hist_first [NBINS];
    logic [31:0] pq_key [HEAP_CAP];
    logic [7:0]  pq_sym [HEAP_CAP];
    int          pq_len;

    t_in_word    pending_cmds[$];
    t_out_word   expected_words[$];
    int          errors = 0;
    int          words_checked = 0;
    int          cycles = 0;
    int          gap_left = 0;
    bit          stim_done = 0;
    int          n_extract = 0;
    int          n_full = 0;
    int          n_sat = 0;

    function automatic void pq_swap(int a, int b);
        logic [31:0] k;
        logic [7:0]  s;
        k = pq_key[a]; pq_key[a] = pq_key[b]; pq_key[b] = k;
        s = pq_sym[a]; pq_sym[a] = pq_sym[b]; pq_sym[b] = s;
    endfunction

    function automatic void pq_sink(int pos);
        int lc;
        int ch;
        while (1) begin
            lc = 2 * pos + 1;
            if (lc >= pq_len) return;
            ch = lc;
            if (lc + 1 < pq_len && pq_key[lc + 1] < pq_key[lc]) ch = lc + 1;
            if (pq_key[pos] > pq_key[ch]) begin
                pq_swap(pos, ch);
                pos = ch;
            end else begin
                return;
            end
        end
    endfunction

    // compute the result word for one command and update the shadow state
    function automatic t_out_word histo_heap_apply(t_in_word w);
        t_out_word r;
        int b;
        int n;
        int pos;
        r = '0;
        case (w.op)
            OP_COUNT: begin
                b = w.byte_value % NBINS;
                if (hist_cnt[b] == 0) hist_first[b] = w.byte_value;
                if (hist_cnt[b] == 32'hFFFF_FFFF) begin
                    r.status = ST_FULL;
                    n_sat++;
                end else begin
                    hist_cnt[b]++;
                end
                r.out_key = hist_cnt[b];
                r.out_symbol = hist_first[b];
            end
            OP_BUILD: begin
                n = 0;
                for (int i = 0; i < NBINS; i++) begin
                    if (hist_cnt[i] != 0 && n < HEAP_CAP) begin
                        pq_key[n] = hist_cnt[i];
                        pq_sym[n] = hist_first[i];
                        n++;
                    end
                end
                pq_len = n;
                for (int i = n / 2 - 1; i >= 0; i--) pq_sink(i);
            end
            OP_EXTRACT: begin
                if (pq_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    n_extract++;
                    r.out_key = pq_key[0];
                    r.out_symbol = pq_sym[0];
                    pq_len--;
                    pq_key[0] = pq_key[pq_len];
                    pq_sym[0] = pq_sym[pq_len];
                    pq_sink(0);
                end
            end
            default: begin
                if (pq_len >= HEAP_CAP) begin
                    r.status = ST_FULL;
                    n_full++;
                end else begin
                    pos = pq_len;
                    pq_key[pos] = w.new_key;
                    pq_sym[pos] = w.new_symbol;
                    while (pos > 0 && pq_key[pos] < pq_key[(pos - 1) / 2]) begin
                        pq_swap(pos, (pos - 1) / 2);
                        pos = (pos - 1) / 2;
                    end
                    pq_len++;
                end
            end
        endcase
        r.heap_count = pq_len[8:0];
        return r;
    endfunction

    function automatic t_in_word mk_cmd(logic [1:0] op, logic [7:0] bv,
                                        logic [31:0] k, logic [7:0] s);
        t_in_word w;
        w.op = op; w.byte_value = bv; w.new_key = k; w.new_symbol = s;
        return w;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // issue commands from the pending queue, with random gaps
    always @(posedge clk) begin : drv
        int g;
        if (!rst_n) begin
            start <= 1'b0;
        end else if (start && !busy) begin
            // the word on the ports is taken at this edge
            expected_words.push_back(histo_heap_apply(cmd_word));
            void'(pending_cmds.pop_front());
            g = pick_gap();
            if (g == 0 && pending_cmds.size() > 0) begin
                cmd_word <= pending_cmds[0];
            end else begin
                start <= 1'b0;
                gap_left <= g;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_cmds.size() > 0) begin
                start <= 1'b1;
                cmd_word <= pending_cmds[0];
            end
        end
    end

    // compare each result word against the oldest expectation
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && res_valid) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                words_checked++;
                if (res_word.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, res_word.status);
                    errors++;
                end
                if (res_word.out_key !== e.out_key) begin
                    $error("out_key exp %0h got %0h", e.out_key, res_word.out_key);
                    errors++;
                end
                if (res_word.out_symbol !== e.out_symbol) begin
                    $error("out_symbol exp %0h got %0h", e.out_symbol,
                           res_word.out_symbol);
                    errors++;
                end
                if (res_word.heap_count !== e.heap_count) begin
                    $error("heap_count exp %0d got %0d", e.heap_count,
                           res_word.heap_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        int r;
        for (int i = 0; i < NBINS; i++) begin
            hist_cnt[i] = '0;
            hist_first[i] = '0;
        end
        pq_len = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty extract, aliasing of 0 and 255, builds, ties, extremes
        pending_cmds.push_back(mk_cmd(OP_EXTRACT, 8'hFF, '1, 8'hFF));
        pending_cmds.push_back(mk_cmd(OP_BUILD, 8'd0, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_COUNT, 8'd255, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_COUNT, 8'd0, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_COUNT, 8'd254, '1, 8'hFF));
        pending_cmds.push_back(mk_cmd(OP_COUNT, 8'd1, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_COUNT, 8'd1, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_BUILD, 8'd0, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_INSERT, 8'd0, 32'd0, 8'hAA));
        pending_cmds.push_back(mk_cmd(OP_INSERT, 8'd0, 32'hFFFF_FFFF, 8'h55));
        pending_cmds.push_back(mk_cmd(OP_INSERT, 8'd0, 32'd1, 8'h01));
        for (int i = 0; i < 7; i++)
            pending_cmds.push_back(mk_cmd(OP_EXTRACT, 8'd0, 32'd0, 8'd0));
        // fill every bin, then build a heap of 255 and top it up to full
        for (int i = 0; i < 256; i++)
            pending_cmds.push_back(mk_cmd(OP_COUNT, i[7:0], 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_BUILD, 8'd0, 32'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(OP_INSERT, 8'd0, 32'd2, 8'h12));
        pending_cmds.push_back(mk_cmd(OP_INSERT, 8'd0, 32'd0, 8'h34));

        // random: mostly inserts and extracts around a live heap
        for (int i = 0; i < RAND_OPS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                pending_cmds.push_back(mk_cmd(OP_COUNT, 8'($urandom), 32'($urandom),
                                              8'($urandom)));
            else if (r < 33)
                pending_cmds.push_back(mk_cmd(OP_BUILD, 8'($urandom), 32'($urandom),
                                              8'($urandom)));
            else if (r < 65)
                pending_cmds.push_back(mk_cmd(OP_EXTRACT, 8'($urandom), 32'($urandom),
                                              8'($urandom)));
            else
                pending_cmds.push_back(mk_cmd(OP_INSERT, 8'($urandom), rand_key(),
                                              8'($urandom)));
        end

        wait (pending_cmds.size() == 0 && !start && expected_words.size() == 0);
        repeat (200) @(posedge clk);
        stim_done = 1;
    end

    initial begin
        wait (stim_done || cycles >= CYCLE_CAP);
        if (!stim_done) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            if (expected_words.size() != 0) errors++;
            $display("Checked %0d words: %0d extracts, %0d full inserts, %0d saturated",
                     words_checked, n_extract, n_full, n_sat);
            if (errors == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
            $finish;
        end
    end
endmodule
